### rtl/nrpe_pkg.sv
// nrpe_pkg: types, constants and digit arithmetic for the nmea rmc position extractor
// used by the channel interfaces and nmea_rmc_position_extractor_core
// no dependencies
package nrpe_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int COORD_W  = 30;
  localparam int DEG_W    = 10;
  localparam int DIGIT_W  = 4;
  localparam int MIN_W    = 7;
  localparam int FRAC_W   = 14;
  localparam int FCNT_W   = 3;

  localparam logic [BYTE_W-1:0] CH_START = 8'h24;
  localparam logic [BYTE_W-1:0] CH_FIX   = 8'h41;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

  localparam int SKIP_LEN      = 18;
  localparam int LON_OFFSET    = 8;
  localparam int FRAC_DIGITS   = 4;
  localparam int UNITS_PER_MIN = 10000;
  localparam int MIN_PER_DEG   = 60;
  localparam int UNITS_PER_DEG = MIN_PER_DEG * UNITS_PER_MIN;

  localparam logic [DEG_W-1:0] DEG_SAT   = 10'd999;
  localparam logic [DEG_W-1:0] DEG_LIMIT = 10'd100;

  localparam logic [STATUS_W-1:0] ST_VALID      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIX     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNUSED     = 2'd3;

  typedef enum logic [6:0] {
    M_HUNT  = 7'b0000001,
    M_SKIP  = 7'b0000010,
    M_LAT_W = 7'b0000100,
    M_LAT_F = 7'b0001000,
    M_LON_W = 7'b0010000,
    M_LON_F = 7'b0100000,
    M_WAIT  = 7'b1000000
  } mode_t;

  // whole digits kept as degrees plus the two minute digits
  typedef struct packed {
    logic [DEG_W-1:0]   deg;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } whole_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COORD_W-1:0]  lat;
    logic [COORD_W-1:0]  lon;
  } result_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t = b - CH_ZERO;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      return t[DIGIT_W-1:0];
    end
    return '0;
  endfunction

  // shift a digit in; degrees saturate once they reach three digits
  function automatic whole_t whole_push(input whole_t w, input logic [DIGIT_W-1:0] d);
    whole_t r;
    logic [DEG_W+3:0] t;
    t = {4'b0, w.deg} * 14'd10 + {10'b0, w.tens};
    r.deg  = (w.deg >= DEG_LIMIT) ? DEG_SAT : t[DEG_W-1:0];
    r.tens = w.ones;
    r.ones = d;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] combine(input whole_t w,
                                                 input logic [FRAC_W-1:0] f);
    logic [MIN_W-1:0]   m;
    logic [COORD_W-1:0] dpart;
    logic [COORD_W-1:0] mpart;
    m     = MIN_W'(w.tens) * MIN_W'(10) + MIN_W'(w.ones);
    dpart = COORD_W'(w.deg) * COORD_W'(UNITS_PER_DEG);
    mpart = COORD_W'(m) * COORD_W'(UNITS_PER_MIN);
    return dpart + mpart + COORD_W'(f);
  endfunction

endpackage

### rtl/nrpe_rx_if.sv
// nrpe_rx_if: valid/ready channel carrying one received character per transfer
// depends on nrpe_pkg
interface nrpe_rx_if;
  logic                          valid;
  logic                          ready;
  logic [nrpe_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/nrpe_pos_if.sv
// nrpe_pos_if: valid/ready channel carrying one position result per transfer
// depends on nrpe_pkg
interface nrpe_pos_if;
  logic                            valid;
  logic                            ready;
  logic [nrpe_pkg::STATUS_W-1:0]   status;
  logic [nrpe_pkg::COORD_W-1:0]    latitude_units;
  logic [nrpe_pkg::COORD_W-1:0]    longitude_units;

  modport source (output valid, output status, output latitude_units,
                  output longitude_units, input ready);
  modport sink (input valid, input status, input latitude_units,
                input longitude_units, output ready);
endinterface

### rtl/nmea_rmc_position_extractor_core.sv
// nmea_rmc_position_extractor_core: rmc sentence parser, one character per transfer
// depends on nrpe_pkg, nrpe_rx_if, nrpe_pos_if
// a result is registered on the line end, or on the status character without a fix
// throughput: one character per cycle unless the skid register is full; an output
// register and a skid register keep the input open while one result waits downstream
// reset: parser returns to hunting for the start character, output and skid empty
module nmea_rmc_position_extractor_core #(
  parameter int MAX_LINE = 100
) (
  input  logic         clk,
  input  logic         rst,
  nrpe_rx_if.sink      rx,
  nrpe_pos_if.source   pos
);
  import nrpe_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE + 1);

  mode_t              mode, mode_next;
  logic [POS_W-1:0]   pos_cnt, pos_cnt_next;
  whole_t             whole, whole_next;
  logic [FRAC_W-1:0]  frac, frac_next;
  logic [FCNT_W-1:0]  frac_cnt, frac_cnt_next;
  logic [COORD_W-1:0] lat_hold, lat_hold_next;

  result_t            out_reg, skid_reg, res;
  logic               out_valid, skid_valid;
  logic               acc, produce, pop;

  logic [BYTE_W-1:0]  b;
  logic [DIGIT_W-1:0] d;
  logic [FRAC_W-1:0]  frac_push;

  assign rx.ready = !skid_valid;
  assign acc      = rx.valid && rx.ready;
  assign pop      = out_valid && pos.ready;
  assign b        = rx.rx_byte;
  assign d        = digit_of(b);
  assign frac_push = FRAC_W'(frac * FRAC_W'(10) + FRAC_W'(d));

  always_comb begin
    mode_next     = mode;
    pos_cnt_next  = pos_cnt;
    whole_next    = whole;
    frac_next     = frac;
    frac_cnt_next = frac_cnt;
    lat_hold_next = lat_hold;
    produce       = 1'b0;
    res.status    = ST_INCOMPLETE;
    res.lat       = '0;
    res.lon       = '0;
    if (acc) begin
      case (mode)
        M_HUNT: begin
          if (b == CH_START) begin
            mode_next    = M_SKIP;
            pos_cnt_next = '0;
          end
        end
        M_SKIP: begin
          pos_cnt_next = pos_cnt + POS_W'(1);
          if (pos_cnt_next == POS_W'(SKIP_LEN)) begin
            if (b != CH_FIX) begin
              produce    = 1'b1;
              res.status = ST_NO_FIX;
              mode_next  = M_HUNT;
            end else begin
              mode_next     = M_LAT_W;
              pos_cnt_next  = '0;
              whole_next    = '0;
              frac_next     = '0;
              frac_cnt_next = '0;
              lat_hold_next = '0;
            end
          end
        end
        default: begin
          if (b == CH_LF) begin
            produce   = 1'b1;
            mode_next = M_HUNT;
            if (mode == M_WAIT) begin
              res.status = ST_VALID;
              res.lat    = lat_hold;
              res.lon    = combine(whole, frac);
            end
          end else if (pos_cnt >= POS_W'(MAX_LINE)) begin
            produce   = 1'b1;
            mode_next = M_HUNT;
          end else begin
            pos_cnt_next = pos_cnt + POS_W'(1);
            case (mode)
              M_LAT_W: begin
                if (pos_cnt != '0) begin
                  if (b == CH_DOT) begin
                    mode_next     = M_LAT_F;
                    frac_cnt_next = '0;
                    frac_next     = '0;
                  end else begin
                    whole_next = whole_push(whole, d);
                  end
                end
              end
              M_LAT_F: begin
                if (frac_cnt >= FCNT_W'(LON_OFFSET - 1)) begin
                  frac_next     = '0;
                  frac_cnt_next = '0;
                  if (b == CH_DOT) begin
                    mode_next  = M_LON_F;
                    whole_next = '0;
                  end else begin
                    mode_next  = M_LON_W;
                    whole_next = whole_push('0, d);
                  end
                end else begin
                  frac_cnt_next = frac_cnt + FCNT_W'(1);
                  if (frac_cnt_next <= FCNT_W'(FRAC_DIGITS)) begin
                    frac_next = frac_push;
                  end
                  if (frac_cnt_next == FCNT_W'(FRAC_DIGITS)) begin
                    lat_hold_next = combine(whole, frac_push);
                  end
                end
              end
              M_LON_W: begin
                if (b == CH_DOT) begin
                  mode_next     = M_LON_F;
                  frac_cnt_next = '0;
                  frac_next     = '0;
                end else begin
                  whole_next = whole_push(whole, d);
                end
              end
              M_LON_F: begin
                frac_cnt_next = frac_cnt + FCNT_W'(1);
                frac_next     = frac_push;
                if (frac_cnt_next >= FCNT_W'(FRAC_DIGITS)) begin
                  mode_next = M_WAIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_HUNT;
      pos_cnt  <= '0;
      whole    <= '0;
      frac     <= '0;
      frac_cnt <= '0;
      lat_hold <= '0;
    end else begin
      mode     <= mode_next;
      pos_cnt  <= pos_cnt_next;
      whole    <= whole_next;
      frac     <= frac_next;
      frac_cnt <= frac_cnt_next;
      lat_hold <= lat_hold_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_reg   <= res;
        out_valid <= produce;
      end
    end else if (produce) begin
      skid_reg   <= res;
      skid_valid <= 1'b1;
    end
  end

  assign pos.valid           = out_valid;
  assign pos.status          = out_reg.status;
  assign pos.latitude_units  = out_reg.lat;
  assign pos.longitude_units = out_reg.lon;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos_cnt <= POS_W'(MAX_LINE))
    else $error("line position beyond maximum");

  a_lon_frac_cnt: assert property (@(posedge clk) disable iff (rst)
    (mode == M_LON_F) |-> (frac_cnt < FCNT_W'(FRAC_DIGITS)))
    else $error("longitude fraction count overran");

  a_digits_bound: assert property (@(posedge clk) disable iff (rst)
    (whole.tens <= DIGIT_W'(9)) && (whole.ones <= DIGIT_W'(9)) && (whole.deg <= DEG_SAT))
    else $error("whole digit register out of range");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_reg.status != ST_UNUSED))
    else $error("result carries an unused status code");

endmodule
